FILE: rtl/s20_pkg.sv
package s20_pkg;

	localparam int WORD_W    = 32;
	localparam int NUM_WORDS = 16;
	localparam int BYTE_W    = 8;
	localparam int POS_W     = 7;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_W     = 64;

	typedef logic [WORD_W-1:0] word_t;
	typedef word_t [NUM_WORDS-1:0] block_t;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_KEY0  = 3'd0,
		CFG_KEY1  = 3'd1,
		CFG_KEY2  = 3'd2,
		CFG_KEY3  = 3'd3,
		CFG_NONCE = 3'd4
	} cfg_idx_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ROUND,
		ST_ADD,
		ST_EMIT
	} state_t;

	// controller to datapath commands
	typedef struct packed {
		logic restart;
		logic load_init;
		logic round_step;
		logic row_round;
		logic second_half;
		logic feed_fwd;
		logic emit_direct;
		logic emit_held;
	} dp_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic need_block;
		logic out_free;
	} dp_stat_t;

	// "expand 32-byte k"
	localparam word_t SIGMA [4] = '{32'h61707865, 32'h3320646e, 32'h79622d32, 32'h6b206574};

	// quarter-round word indexes a, b, c, d
	localparam logic [3:0] COL_IDX [4][4] = '{
		'{4'd0,  4'd4,  4'd8,  4'd12},
		'{4'd5,  4'd9,  4'd13, 4'd1},
		'{4'd10, 4'd14, 4'd2,  4'd6},
		'{4'd15, 4'd3,  4'd7,  4'd11}
	};
	localparam logic [3:0] ROW_IDX [4][4] = '{
		'{4'd0,  4'd1,  4'd2,  4'd3},
		'{4'd5,  4'd6,  4'd7,  4'd4},
		'{4'd10, 4'd11, 4'd8,  4'd9},
		'{4'd15, 4'd12, 4'd13, 4'd14}
	};

	function automatic word_t rotl(word_t v, int unsigned s);
		return (v << s) | (v >> (WORD_W - s));
	endfunction

endpackage

FILE: rtl/salsa20_stream_cipher_top.sv
// Salsa20 stream cipher, one byte per word. Load the key and nonce through the
// write port while idle; a nonce write also restarts the block counter. Each
// data word (tuser low) leaves XORed with the next keystream byte, with tlast
// passed through; a word with tlast set ends the message and drops the rest of
// the current keystream block. A word with tuser high restarts the block
// counter at zero and gives no output. A byte from a block already held is
// registered at the output in the next cycle, so such bytes stream at one
// per clock while the output is not stalled. The first byte of a message and
// every 64th byte after it start a new block: initial load, half-round steps
// of two add-rotate-xor steps of each quarter round, feed-forward add, output.
module salsa20_stream_cipher_top #(
	parameter int ROUNDS = 20
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	input  logic [s20_pkg::BYTE_W-1:0]        s_axis_tdata,  // data_in[7:0]
	input  logic                              s_axis_tlast,
	input  logic                              s_axis_tuser,  // op
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	output logic [s20_pkg::BYTE_W-1:0]        m_axis_tdata,  // data_out[7:0]
	output logic                              m_axis_tlast,
	input  logic                              cfg_we,
	input  logic [s20_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [s20_pkg::CFG_W-1:0]         cfg_wdata
);
	import s20_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	s20_ctrl #(
		.ROUNDS(ROUNDS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_axis_tvalid),
		.s_tuser  (s_axis_tuser),
		.s_tready (s_axis_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	s20_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.s_tdata   (s_axis_tdata),
		.s_tlast   (s_axis_tlast),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.m_tvalid  (m_axis_tvalid),
		.m_tready  (m_axis_tready),
		.m_tdata   (m_axis_tdata),
		.m_tlast   (m_axis_tlast)
	);

endmodule

FILE: rtl/s20_ctrl.sv
module s20_ctrl #(
	parameter int ROUNDS = 20
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	input  logic             s_tuser,
	output logic             s_tready,
	input  s20_pkg::dp_stat_t stat,
	output s20_pkg::dp_cmd_t  cmd
);
	import s20_pkg::*;

	localparam int STEP_W = $clog2(2 * ROUNDS);
	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(2 * ROUNDS - 1);

	state_t state_q, state_d;
	logic [STEP_W-1:0] step_q;
	logic accept;

	assign accept = s_tvalid && s_tready;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// half-round step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else if (cmd.load_init) begin
			step_q <= '0;
		end else if (cmd.round_step) begin
			step_q <= step_q + 1'b1;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && !s_tuser && stat.need_block) state_d = ST_ROUND;
			end
			ST_ROUND: begin
				if (step_q == LAST_STEP) state_d = ST_ADD;
			end
			ST_ADD: begin
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (stat.out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd             = '0;
		s_tready        = 1'b0;
		cmd.row_round   = step_q[1];
		cmd.second_half = step_q[0];
		unique case (state_q)
			ST_IDLE: begin
				s_tready = stat.out_free;
				if (accept) begin
					if (s_tuser) begin
						cmd.restart = 1'b1;
					end else if (stat.need_block) begin
						cmd.load_init = 1'b1;
					end else begin
						cmd.emit_direct = 1'b1;
					end
				end
			end
			ST_ROUND: cmd.round_step = 1'b1;
			ST_ADD:   cmd.feed_fwd = 1'b1;
			ST_EMIT:  cmd.emit_held = stat.out_free;
			default: ;
		endcase
	end

	ready_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_IDLE |-> !s_tready)
		else $error("input ready while a block is being made");

	rounds_then_add: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ROUND && step_q == LAST_STEP) |=> state_q == ST_ADD)
		else $error("round sequence did not end in feed-forward");

	add_then_emit: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.feed_fwd |=> state_q == ST_EMIT)
		else $error("feed-forward not followed by emit");

endmodule

FILE: rtl/s20_dp.sv
module s20_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  s20_pkg::dp_cmd_t                  cmd,
	output s20_pkg::dp_stat_t                 stat,
	input  logic [s20_pkg::BYTE_W-1:0]        s_tdata,
	input  logic                              s_tlast,
	input  logic                              cfg_we,
	input  logic [s20_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [s20_pkg::CFG_W-1:0]         cfg_wdata,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [s20_pkg::BYTE_W-1:0]        m_tdata,
	output logic                              m_tlast
);
	import s20_pkg::*;

	localparam logic [POS_W-1:0] POS_NONE = POS_W'(64);

	logic [CFG_W-1:0]  key_q [4];
	logic [CFG_W-1:0]  nonce_q;
	logic [CFG_W-1:0]  ctr_q;
	block_t            x_q;
	logic [POS_W-1:0]  pos_q;
	logic [BYTE_W-1:0] hold_data_q;
	logic              hold_last_q;
	logic              out_valid_q;
	logic [BYTE_W-1:0] out_data_q;
	logic              out_last_q;

	block_t            init_w;
	block_t            round_nxt;
	word_t             ks_word;
	logic [BYTE_W-1:0] ks_byte;
	logic              nonce_wr;

	assign nonce_wr = cfg_we && (cfg_index == CFG_NONCE);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) key_q[i] <= '0;
			nonce_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_KEY0:  key_q[0] <= cfg_wdata;
				CFG_KEY1:  key_q[1] <= cfg_wdata;
				CFG_KEY2:  key_q[2] <= cfg_wdata;
				CFG_KEY3:  key_q[3] <= cfg_wdata;
				CFG_NONCE: nonce_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// block counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctr_q <= '0;
		end else if (cmd.restart || nonce_wr) begin
			ctr_q <= '0;
		end else if (cmd.feed_fwd) begin
			ctr_q <= ctr_q + 1'b1;
		end
	end

	// initial block words
	always_comb begin
		init_w[0]  = SIGMA[0];
		init_w[1]  = key_q[0][31:0];
		init_w[2]  = key_q[0][63:32];
		init_w[3]  = key_q[1][31:0];
		init_w[4]  = key_q[1][63:32];
		init_w[5]  = SIGMA[1];
		init_w[6]  = nonce_q[31:0];
		init_w[7]  = nonce_q[63:32];
		init_w[8]  = ctr_q[31:0];
		init_w[9]  = ctr_q[63:32];
		init_w[10] = SIGMA[2];
		init_w[11] = key_q[2][31:0];
		init_w[12] = key_q[2][63:32];
		init_w[13] = key_q[3][31:0];
		init_w[14] = key_q[3][63:32];
		init_w[15] = SIGMA[3];
	end

	// half of a column or row round: four quarter rounds, two steps each
	always_comb begin
		logic [3:0] ia, ib, ic, id;
		word_t wa, wb, wc, wd, t0, t1;
		round_nxt = x_q;
		for (int j = 0; j < 4; j++) begin
			ia = cmd.row_round ? ROW_IDX[j][0] : COL_IDX[j][0];
			ib = cmd.row_round ? ROW_IDX[j][1] : COL_IDX[j][1];
			ic = cmd.row_round ? ROW_IDX[j][2] : COL_IDX[j][2];
			id = cmd.row_round ? ROW_IDX[j][3] : COL_IDX[j][3];
			wa = x_q[ia];
			wb = x_q[ib];
			wc = x_q[ic];
			wd = x_q[id];
			if (!cmd.second_half) begin
				t0 = wb ^ rotl(wa + wd, 7);
				t1 = wc ^ rotl(t0 + wa, 9);
				round_nxt[ib] = t0;
				round_nxt[ic] = t1;
			end else begin
				t0 = wd ^ rotl(wc + wb, 13);
				t1 = wa ^ rotl(t0 + wc, 18);
				round_nxt[id] = t0;
				round_nxt[ia] = t1;
			end
		end
	end

	// working words, then keystream after feed-forward
	always_ff @(posedge clk) begin
		if (cmd.load_init) begin
			x_q <= init_w;
		end else if (cmd.round_step) begin
			x_q <= round_nxt;
		end else if (cmd.feed_fwd) begin
			for (int i = 0; i < NUM_WORDS; i++) x_q[i] <= x_q[i] + init_w[i];
		end
	end

	// word held while the block is made
	always_ff @(posedge clk) begin
		if (cmd.load_init) begin
			hold_data_q <= s_tdata;
			hold_last_q <= s_tlast;
		end
	end

	// byte position within the block
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= POS_NONE;
		end else if (cmd.feed_fwd) begin
			pos_q <= '0;
		end else if (cmd.emit_direct) begin
			pos_q <= s_tlast ? POS_NONE : pos_q + 1'b1;
		end else if (cmd.emit_held) begin
			pos_q <= hold_last_q ? POS_NONE : pos_q + 1'b1;
		end
	end

	// keystream byte select
	assign ks_word = x_q[pos_q[5:2]];
	assign ks_byte = ks_word[{pos_q[1:0], 3'b000} +: BYTE_W];

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit_direct || cmd.emit_held) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_direct) begin
			out_data_q <= s_tdata ^ ks_byte;
			out_last_q <= s_tlast;
		end else if (cmd.emit_held) begin
			out_data_q <= hold_data_q ^ ks_byte;
			out_last_q <= hold_last_q;
		end
	end

	assign m_tvalid        = out_valid_q;
	assign m_tdata         = out_data_q;
	assign m_tlast         = out_last_q;
	assign stat.need_block = pos_q[6];
	assign stat.out_free   = !out_valid_q || m_tready;

	pos_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= POS_NONE)
		else $error("byte position beyond block");

	held_at_block_start: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_held |-> pos_q == '0)
		else $error("held word emitted away from block start");

	ctr_steps_once: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.feed_fwd |=> ctr_q == $past(ctr_q) + 64'd1)
		else $error("block counter did not advance by one");

endmodule
